FILE: rtl/core/two_walker_grid_max_path_sum_macros.svh
// Assertion macros for the two-walker grid max path sum block.
`ifndef TWO_WALKER_GRID_MAX_PATH_SUM_MACROS_SVH
`define TWO_WALKER_GRID_MAX_PATH_SUM_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define TWG_ASSERT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Implication checked in the next cycle.
`define TWG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define TWG_ASSERT(lbl, clk, rst_n, pre, post, msg)
`define TWG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: rtl/core/twgmps_pkg.sv
// Shared constants and types for the two-walker grid max path sum block.
package twgmps_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam int CFG_W       = 7;   // row_count / col_count register width
  localparam int CELL_W      = 16;  // cell_value field width
  localparam int TOTAL_W     = 23;  // best_total field width
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    S_LOAD,   // taking grid cells
    S_READ,   // issuing the nine neighbor reads of one column pair
    S_DRAIN,  // last neighbor read returns
    S_WRITE   // write the pair's value back
  } state_e;

endpackage

FILE: rtl/core/two_walker_grid_max_path_sum.sv
// Load: one cell per cycle, except that the last cell waits while a result is
// still unread. Compute after the last cell, for every row and column pair: 9
// neighbor reads on the single DP memory read port, a drain and a write. No
// input is taken during compute.
// Reset clears the size registers to 1 and the cell counter; the grid and DP
// memories hold no reset value, and no entry is used before it is written.
module two_walker_grid_max_path_sum #(
  parameter int MAX_ROWS   = twgmps_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = twgmps_pkg::DEF_MAX_COLS,
  parameter int VALUE_BITS = twgmps_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [twgmps_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [twgmps_pkg::CFG_W-1:0]        cfg_wdata_i,
  // cell stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [twgmps_pkg::TDATA_IN_W-1:0]   s_axis_tdata,   // [15:0] cell_value
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [twgmps_pkg::TDATA_OUT_W-1:0]  m_axis_tdata    // [22:0] best_total, [23] zero
);

  localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
  localparam int COLS_W     = $clog2(MAX_COLS + 1);
  localparam int RIDX_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int CNT_W      = $clog2(GRID_DEPTH + 1);
  localparam int TOT_W      = ROWS_W + COLS_W;
  localparam int DP_AW      = 1 + 2 * COL_W;
  localparam int DP_DEPTH   = 2 ** DP_AW;
  localparam int ACC_W      = VALUE_BITS + 1 + $clog2(MAX_ROWS);
  localparam int IN_BITS    = (VALUE_BITS < twgmps_pkg::CELL_W) ? VALUE_BITS
                                                                : twgmps_pkg::CELL_W;

  // ---------------------------------------------------------------- config
  logic [twgmps_pkg::CFG_W-1:0] row_count_q, col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= twgmps_pkg::CFG_W'(1);
      col_count_q <= twgmps_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        twgmps_pkg::REG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        twgmps_pkg::REG_COL_COUNT: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [TOT_W-1:0]  total;

  always_comb begin
    if (row_count_q == '0)             rows_eff = ROWS_W'(1);
    else if (32'(row_count_q) > MAX_ROWS) rows_eff = ROWS_W'(MAX_ROWS);
    else                               rows_eff = ROWS_W'(row_count_q);
    if (col_count_q == '0)             cols_eff = COLS_W'(1);
    else if (32'(col_count_q) > MAX_COLS) cols_eff = COLS_W'(MAX_COLS);
    else                               cols_eff = COLS_W'(col_count_q);
    total = TOT_W'(rows_eff) * TOT_W'(cols_eff);
  end

  // ---------------------------------------------------------------- state
  twgmps_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]      cells_loaded_q;
  logic [RIDX_W-1:0]     r_q;
  logic [COL_W-1:0]      cols_m1_q;
  logic [GRID_AW-1:0]    row_base_q;
  logic [COL_W-1:0]      a_q, b_q;
  logic [1:0]            da_q, db_q;     // neighbor offset + 1
  logic                  wr_bank_q;
  logic                  first_row_q;
  logic [ACC_W-1:0]      best_q;
  logic [VALUE_BITS-1:0] gain_a_q, gain_b_q;
  logic                  nb_ok_q, cap_a_q, cap_b_q;
  logic                  m_valid_q;
  logic [twgmps_pkg::TOTAL_W-1:0] result_q;

  logic                  s_fire, last_cell;
  logic [VALUE_BITS-1:0] cell_v;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign last_cell = (TOT_W'(cells_loaded_q) + TOT_W'(1)) >= total;
  assign cell_v    = VALUE_BITS'(s_axis_tdata[IN_BITS-1:0]);
  assign s_axis_tready = (state_q == twgmps_pkg::S_LOAD) && !(m_valid_q && last_cell);

  // ---------------------------------------------------------------- memories
  logic [VALUE_BITS-1:0] grid_mem [GRID_DEPTH];
  logic [VALUE_BITS-1:0] grid_rd_q;
  logic [GRID_AW-1:0]    grid_raddr;

  logic [ACC_W-1:0]      dp_mem [DP_DEPTH];
  logic [ACC_W-1:0]      dp_rd_q;
  logic [DP_AW-1:0]      dp_raddr, dp_waddr;
  logic [ACC_W-1:0]      dp_wdata;
  logic                  dp_we;

  always_ff @(posedge clk_i) begin
    if (s_fire) grid_mem[cells_loaded_q[GRID_AW-1:0]] <= cell_v;
    grid_rd_q <= grid_mem[grid_raddr];
  end

  // Reads go to the bank of the row below, writes to the other bank: no overlap.
  always_ff @(posedge clk_i) begin
    if (dp_we) dp_mem[dp_waddr] <= dp_wdata;
    dp_rd_q <= dp_mem[dp_raddr];
  end

  // ---------------------------------------------------------------- datapath
  logic             issue, nb_valid, nb_last, pair_last, row_last, take_result;
  logic [COL_W-1:0] na, nb;
  logic [ACC_W-1:0] gain_sum, new_val;
  logic [twgmps_pkg::TOTAL_W-1:0] new_sat;

  always_comb begin
    issue    = (state_q == twgmps_pkg::S_READ);
    na       = a_q + COL_W'(da_q) - COL_W'(1);
    nb       = b_q + COL_W'(db_q) - COL_W'(1);
    nb_valid = !first_row_q
               && !(da_q == 2'd0 && a_q == '0) && !(da_q == 2'd2 && a_q == cols_m1_q)
               && !(db_q == 2'd0 && b_q == '0) && !(db_q == 2'd2 && b_q == cols_m1_q);
    nb_last  = (da_q == 2'd2) && (db_q == 2'd2);
    dp_raddr = {~wr_bank_q, na, nb};
    // row cell of walker a on the first issue slot, walker b on the second
    grid_raddr = row_base_q + GRID_AW'((db_q == 2'd0) ? a_q : b_q);
    gain_sum = (a_q == b_q) ? ACC_W'(gain_a_q)
                            : ACC_W'(gain_a_q) + ACC_W'(gain_b_q);
    new_val  = best_q + gain_sum;
    dp_we    = (state_q == twgmps_pkg::S_WRITE);
    dp_waddr = {wr_bank_q, a_q, b_q};
    dp_wdata = new_val;
    pair_last   = (a_q == cols_m1_q) && (b_q == cols_m1_q);
    row_last    = (r_q == '0);
    take_result = dp_we && row_last && (a_q == '0) && (b_q == cols_m1_q);
  end

  generate
    if (ACC_W > twgmps_pkg::TOTAL_W) begin : g_sat
      assign new_sat = (|new_val[ACC_W-1:twgmps_pkg::TOTAL_W]) ? twgmps_pkg::TOTAL_MAX
                                                             : new_val[twgmps_pkg::TOTAL_W-1:0];
    end else begin : g_nosat
      assign new_sat = twgmps_pkg::TOTAL_W'(new_val);
    end
  endgenerate

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twgmps_pkg::S_LOAD:  if (s_fire && last_cell) state_d = twgmps_pkg::S_READ;
      twgmps_pkg::S_READ:  if (nb_last) state_d = twgmps_pkg::S_DRAIN;
      twgmps_pkg::S_DRAIN: state_d = twgmps_pkg::S_WRITE;
      twgmps_pkg::S_WRITE: state_d = (pair_last && row_last) ? twgmps_pkg::S_LOAD
                                                             : twgmps_pkg::S_READ;
      default:             state_d = twgmps_pkg::S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= twgmps_pkg::S_LOAD;
      cells_loaded_q <= '0;
      r_q            <= '0;
      cols_m1_q      <= '0;
      row_base_q     <= '0;
      a_q            <= '0;
      b_q            <= '0;
      da_q           <= '0;
      db_q           <= '0;
      wr_bank_q      <= 1'b0;
      first_row_q    <= 1'b0;
      nb_ok_q        <= 1'b0;
      cap_a_q        <= 1'b0;
      cap_b_q        <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      nb_ok_q <= issue && nb_valid;
      cap_a_q <= issue && (da_q == 2'd0) && (db_q == 2'd0);
      cap_b_q <= issue && (da_q == 2'd0) && (db_q == 2'd1);
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      if (s_fire) begin
        if (last_cell) begin
          cells_loaded_q <= '0;
          r_q            <= RIDX_W'(rows_eff - ROWS_W'(1));
          cols_m1_q      <= COL_W'(cols_eff - COLS_W'(1));
          row_base_q     <= GRID_AW'(total - TOT_W'(cols_eff));
          a_q            <= '0;
          b_q            <= '0;
          da_q           <= '0;
          db_q           <= '0;
          first_row_q    <= 1'b1;
        end else begin
          cells_loaded_q <= cells_loaded_q + CNT_W'(1);
        end
      end

      if (issue) begin
        if (db_q == 2'd2) begin
          db_q <= '0;
          da_q <= da_q + 2'd1;
        end else begin
          db_q <= db_q + 2'd1;
        end
      end

      if (dp_we) begin
        da_q <= '0;
        db_q <= '0;
        if (pair_last) begin
          a_q         <= '0;
          b_q         <= '0;
          r_q         <= r_q - RIDX_W'(1);
          row_base_q  <= row_base_q - (GRID_AW'(cols_m1_q) + GRID_AW'(1));
          wr_bank_q   <= ~wr_bank_q;
          first_row_q <= 1'b0;
          if (row_last) m_valid_q <= 1'b1;
        end else if (b_q == cols_m1_q) begin
          b_q <= '0;
          a_q <= a_q + COL_W'(1);
        end else begin
          b_q <= b_q + COL_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire || dp_we)                best_q <= '0;
    else if (nb_ok_q && dp_rd_q > best_q) best_q <= dp_rd_q;
    if (cap_a_q)     gain_a_q <= grid_rd_q;
    if (cap_b_q)     gain_b_q <= grid_rd_q;
    if (take_result) result_q <= new_sat;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, result_q};

  // ---------------------------------------------------------------- checks
  `include "two_walker_grid_max_path_sum_macros.svh"

  `TWG_ASSERT(a_cnt_idle, clk_i, rst_ni, state_q != twgmps_pkg::S_LOAD, cells_loaded_q == '0, "cell counter not cleared during compute")
  `TWG_ASSERT(a_off_range, clk_i, rst_ni, issue, da_q != 2'd3 && db_q != 2'd3, "neighbor offset out of range")
  `TWG_ASSERT(a_bank_split, clk_i, rst_ni, dp_we, dp_waddr[DP_AW-1] != dp_raddr[DP_AW-1], "DP write hits read bank")
  `TWG_ASSERT_NEXT(a_res_src, clk_i, rst_ni, !m_valid_q && !(state_q == twgmps_pkg::S_WRITE && pair_last && row_last), !m_valid_q, "result valid without finishing top row")

endmodule
